[rtl/core/bjt_pkg.sv]
// Shared constants and types for the backup job tracker.
package bjt_pkg;

    localparam int unsigned OPC_W   = 3;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned STAT_W  = 32;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [OPC_W-1:0]   t_opcode;
    typedef logic [STATE_W-1:0] t_state;
    typedef logic [CODE_W-1:0]  t_code;

    localparam t_opcode OP_START_REQ  = 3'd0;
    localparam t_opcode OP_START_ACK  = 3'd1;
    localparam t_opcode OP_REPORT     = 3'd2;
    localparam t_opcode OP_CANCEL_REQ = 3'd3;
    localparam t_opcode OP_CANCEL_ACK = 3'd4;
    localparam t_opcode OP_POWER_DROP = 3'd5;

    localparam t_state ST_IDLE      = 3'd0;
    localparam t_state ST_STARTING  = 3'd1;
    localparam t_state ST_RUNNING   = 3'd2;
    localparam t_state ST_CANCELING = 3'd3;
    localparam t_state ST_DONE      = 3'd4;
    localparam t_state ST_FAILED    = 3'd5;
    localparam t_state ST_CANCELLED = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_FAILED_CODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANCELLED_CODE = 1'd1;

    localparam t_code FAILED_CODE_RST    = 8'd9;
    localparam t_code CANCELLED_CODE_RST = 8'd11;

endpackage

[rtl/core/backup_job_tracker.sv]
// Backup job tracker: one event per transaction, one status transaction out.
// An accepted event is held in the event register; its result is then held in
// the result register. Throughput: one event per cycle while the result is
// not stalled; the next job record is worked out combinationally in between.
// Reset (synchronous, active low) clears the record to idle, the change
// counter to zero and loads the failed and cancelled codes with 9 and 11.
module backup_job_tracker
    import bjt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CODE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [OPC_W-1:0]     i_opcode,
    input  logic [CODE_W-1:0]    i_err_code,
    input  logic [CODE_W-1:0]    i_sub_err,
    input  logic                 i_is_ext,
    input  logic [CODE_W-1:0]    i_phase,
    input  logic [CODE_W-1:0]    i_progress,
    input  logic [STAT_W-1:0]    i_file_count,
    input  logic [STAT_W-1:0]    i_folder_count,
    input  logic [STAT_W-1:0]    i_total_amount,
    input  logic [STAT_W-1:0]    i_elapsed_sec,
    input  logic                 i_send_ok,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STATE_W-1:0]   o_job_state,
    output logic [CODE_W-1:0]    o_last_err,
    output logic [CODE_W-1:0]    o_last_sub_err,
    output logic                 o_has_ext,
    output logic [CODE_W-1:0]    o_cur_phase,
    output logic [CODE_W-1:0]    o_cur_progress,
    output logic                 o_accepted,
    output logic [CNT_W-1:0]     o_change_count
);

    // config
    t_code r_failed_code;
    t_code r_cancelled_code;

    // event register
    logic    r_in_valid;
    t_opcode r_op;
    t_code   r_err;
    t_code   r_sub;
    logic    r_ext;
    t_code   r_ph;
    t_code   r_prog;
    logic    r_stats;
    logic    r_send;

    // job record
    t_state           r_state,    n_state;
    t_code            r_err_rec,  n_err_rec;
    t_code            r_sub_rec,  n_sub_rec;
    logic             r_ext_rec,  n_ext_rec;
    t_code            r_ph_rec,   n_ph_rec;
    t_code            r_prog_rec, n_prog_rec;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic             n_acc;

    // result register
    logic             r_out_valid;
    t_state           r_o_state;
    t_code            r_o_err;
    t_code            r_o_sub;
    logic             r_o_ext;
    t_code            r_o_ph;
    t_code            r_o_prog;
    logic             r_o_acc;
    logic [CNT_W-1:0] r_o_cnt;

    logic advance;
    logic in_flight;
    logic terminal;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed_code    <= FAILED_CODE_RST;
            r_cancelled_code <= CANCELLED_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAILED_CODE:    r_failed_code    <= i_cfg_data;
                CFG_CANCELLED_CODE: r_cancelled_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op    <= i_opcode;
            r_err   <= i_err_code;
            r_sub   <= i_sub_err;
            r_ext   <= i_is_ext;
            r_ph    <= i_phase;
            r_prog  <= i_progress;
            r_stats <= |(i_file_count | i_folder_count | i_total_amount | i_elapsed_sec);
            r_send  <= i_send_ok;
        end
    end

    assign in_flight = (r_state == ST_STARTING) || (r_state == ST_RUNNING) ||
                       (r_state == ST_CANCELING);
    assign terminal  = (r_err == r_failed_code) || (r_err == r_cancelled_code) ||
                       (r_ext && (r_ph == '0)) || (!r_ext && r_stats);

    always_comb begin
        n_state    = r_state;
        n_err_rec  = r_err_rec;
        n_sub_rec  = r_sub_rec;
        n_ext_rec  = r_ext_rec;
        n_ph_rec   = r_ph_rec;
        n_prog_rec = r_prog_rec;
        n_cnt      = r_cnt;
        n_acc      = 1'b0;
        unique case (r_op)
            OP_START_REQ: begin
                if (!in_flight) begin
                    n_state    = r_send ? ST_STARTING : ST_IDLE;
                    n_err_rec  = '0;
                    n_sub_rec  = '0;
                    n_ext_rec  = 1'b0;
                    n_ph_rec   = '0;
                    n_prog_rec = '0;
                    n_acc      = r_send;
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            OP_START_ACK: begin
                if (r_state == ST_STARTING) begin
                    if (r_err == '0) begin
                        n_state = ST_RUNNING;
                    end else begin
                        n_state   = ST_FAILED;
                        n_err_rec = r_err;
                    end
                    n_cnt = r_cnt + 1'b1;
                end
            end
            OP_REPORT: begin
                n_err_rec = r_err;
                n_sub_rec = r_sub;
                n_ext_rec = r_ext;
                if (r_ext) begin
                    n_ph_rec   = r_ph;
                    n_prog_rec = r_prog;
                end
                priority if (in_flight && (r_err == r_cancelled_code)) begin
                    n_state = ST_CANCELLED;
                end else if (in_flight && terminal) begin
                    n_state = (r_err == '0) ? ST_DONE : ST_FAILED;
                end else if (r_state == ST_STARTING) begin
                    n_state = ST_RUNNING;
                end else if ((r_state == ST_IDLE) && r_ext && (r_ph != '0)) begin
                    n_state = ST_RUNNING;
                end else begin
                    n_state = r_state;
                end
                n_cnt = r_cnt + 1'b1;
            end
            OP_CANCEL_REQ: begin
                if (r_state == ST_RUNNING) begin
                    n_acc = r_send;
                end
            end
            OP_CANCEL_ACK: begin
                n_err_rec = r_err;
                if ((r_err == '0) && (r_state == ST_RUNNING)) begin
                    n_state = ST_CANCELING;
                end
                n_cnt = r_cnt + 1'b1;
            end
            OP_POWER_DROP: begin
                n_state    = ST_IDLE;
                n_err_rec  = '0;
                n_sub_rec  = '0;
                n_ext_rec  = 1'b0;
                n_ph_rec   = '0;
                n_prog_rec = '0;
                n_cnt      = r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_err_rec  <= '0;
            r_sub_rec  <= '0;
            r_ext_rec  <= 1'b0;
            r_ph_rec   <= '0;
            r_prog_rec <= '0;
            r_cnt      <= '0;
        end else if (advance) begin
            r_state    <= n_state;
            r_err_rec  <= n_err_rec;
            r_sub_rec  <= n_sub_rec;
            r_ext_rec  <= n_ext_rec;
            r_ph_rec   <= n_ph_rec;
            r_prog_rec <= n_prog_rec;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_state <= n_state;
            r_o_err   <= n_err_rec;
            r_o_sub   <= n_sub_rec;
            r_o_ext   <= n_ext_rec;
            r_o_ph    <= n_ph_rec;
            r_o_prog  <= n_prog_rec;
            r_o_acc   <= n_acc;
            r_o_cnt   <= n_cnt;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_job_state    = r_o_state;
    assign o_last_err     = r_o_err;
    assign o_last_sub_err = r_o_sub;
    assign o_has_ext      = r_o_ext;
    assign o_cur_phase    = r_o_ph;
    assign o_cur_progress = r_o_prog;
    assign o_accepted     = r_o_acc;
    assign o_change_count = r_o_cnt;

endmodule

[rtl/core/bjt_checker.sv]
// Port-level checker for the backup job tracker, with its bind.
module bjt_checker
    import bjt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [STATE_W-1:0] o_job_state,
    input logic [CODE_W-1:0]  o_last_err,
    input logic               o_accepted,
    input logic [CNT_W-1:0]   o_change_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_job_state) &&
        $stable(o_change_count))
        else $error("result transaction dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_acc_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> (o_job_state == ST_STARTING) ||
        (o_job_state == ST_RUNNING))
        else $error("accepted request with job neither starting nor running");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted && (o_job_state == ST_STARTING) |-> o_last_err == '0)
        else $error("accepted start left a stale error");

endmodule

bind backup_job_tracker bjt_checker u_bjt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_job_state    (o_job_state),
    .o_last_err     (o_last_err),
    .o_accepted     (o_accepted),
    .o_change_count (o_change_count)
);

[tb/job_status_checker.sv]
// Checker for the backup job tracker: predicts each status transaction and compares it.
module job_status_checker
    import bjt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CODE_W-1:0]    i_cfg_data,
    input  logic                 i_ev_valid,
    input  logic                 i_ev_ready,
    input  t_opcode              i_ev_opcode,
    input  t_code                i_ev_err_code,
    input  t_code                i_ev_sub_err,
    input  logic                 i_ev_is_ext,
    input  t_code                i_ev_phase,
    input  t_code                i_ev_progress,
    input  logic [STAT_W-1:0]    i_ev_file_count,
    input  logic [STAT_W-1:0]    i_ev_folder_count,
    input  logic [STAT_W-1:0]    i_ev_total_amount,
    input  logic [STAT_W-1:0]    i_ev_elapsed_sec,
    input  logic                 i_ev_send_ok,
    input  logic                 i_st_valid,
    input  logic                 i_st_ready,
    input  t_state               i_st_job_state,
    input  t_code                i_st_last_err,
    input  t_code                i_st_last_sub_err,
    input  logic                 i_st_has_ext,
    input  t_code                i_st_cur_phase,
    input  t_code                i_st_cur_progress,
    input  logic                 i_st_accepted,
    input  logic [CNT_W-1:0]     i_st_change_count,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_state           state;
        t_code            err;
        t_code            sub_err;
        logic             ext;
        t_code            phase;
        t_code            progress;
        logic             accepted;
        logic [CNT_W-1:0] changes;
    } t_job_status;

    t_code       failed_code_cfg;
    t_code       cancelled_code_cfg;
    t_job_status job_rec;
    t_job_status due_head;
    t_job_status status_due_q[$];
    int          fail_total = 0;

    function automatic void clear_record();
        job_rec.state    = ST_IDLE;
        job_rec.err      = '0;
        job_rec.sub_err  = '0;
        job_rec.ext      = 1'b0;
        job_rec.phase    = '0;
        job_rec.progress = '0;
    endfunction

    function automatic t_job_status apply_event(
        input t_opcode op,
        input t_code   err,
        input t_code   sub,
        input logic    ext,
        input t_code   ph,
        input t_code   prog,
        input logic    stats_nz,
        input logic    sent
    );
        logic busy;
        logic terminal;
        busy = (job_rec.state == ST_STARTING) || (job_rec.state == ST_RUNNING) ||
               (job_rec.state == ST_CANCELING);
        job_rec.accepted = 1'b0;
        case (op)
            OP_START_REQ: begin
                if (!busy) begin
                    clear_record();
                    job_rec.state    = sent ? ST_STARTING : ST_IDLE;
                    job_rec.accepted = sent;
                    job_rec.changes++;
                end
            end
            OP_START_ACK: begin
                // stale acknowledges are dropped
                if (job_rec.state == ST_STARTING) begin
                    if (err == '0) begin
                        job_rec.state = ST_RUNNING;
                    end else begin
                        job_rec.state = ST_FAILED;
                        job_rec.err   = err;
                    end
                    job_rec.changes++;
                end
            end
            OP_REPORT: begin
                job_rec.err     = err;
                job_rec.sub_err = sub;
                job_rec.ext     = ext;
                if (ext) begin
                    job_rec.phase    = ph;
                    job_rec.progress = prog;
                end
                terminal = (err == failed_code_cfg) || (err == cancelled_code_cfg) ||
                           (ext && ph == '0) || (!ext && stats_nz);
                if (busy) begin
                    if (err == cancelled_code_cfg) begin
                        job_rec.state = ST_CANCELLED;
                    end else if (terminal) begin
                        job_rec.state = (err == '0) ? ST_DONE : ST_FAILED;
                    end else if (job_rec.state == ST_STARTING) begin
                        job_rec.state = ST_RUNNING;
                    end
                end else if (job_rec.state == ST_IDLE && ext && ph != '0) begin
                    job_rec.state = ST_RUNNING;
                end
                job_rec.changes++;
            end
            OP_CANCEL_REQ: begin
                if (job_rec.state == ST_RUNNING) begin
                    job_rec.accepted = sent;
                end
            end
            OP_CANCEL_ACK: begin
                job_rec.err = err;
                if (err == '0 && job_rec.state == ST_RUNNING) begin
                    job_rec.state = ST_CANCELING;
                end
                job_rec.changes++;
            end
            OP_POWER_DROP: begin
                clear_record();
                job_rec.changes++;
            end
            default: begin
            end
        endcase
        return job_rec;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            failed_code_cfg    = FAILED_CODE_RST;
            cancelled_code_cfg = CANCELLED_CODE_RST;
            job_rec            = '0;
            status_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FAILED_CODE) begin
                    failed_code_cfg = i_cfg_data;
                end else if (i_cfg_idx == CFG_CANCELLED_CODE) begin
                    cancelled_code_cfg = i_cfg_data;
                end
            end
            if (i_st_valid && i_st_ready) begin
                if (status_due_q.size() == 0) begin
                    $error("status transaction with no event waiting for it");
                    fail_total++;
                end else begin
                    due_head = status_due_q.pop_front();
                    check_field("job_state", due_head.state, i_st_job_state);
                    check_field("last_err", due_head.err, i_st_last_err);
                    check_field("last_sub_err", due_head.sub_err, i_st_last_sub_err);
                    check_field("has_ext", due_head.ext, i_st_has_ext);
                    check_field("cur_phase", due_head.phase, i_st_cur_phase);
                    check_field("cur_progress", due_head.progress, i_st_cur_progress);
                    check_field("accepted", due_head.accepted, i_st_accepted);
                    check_field("change_count", due_head.changes, i_st_change_count);
                end
            end
            if (i_ev_valid && i_ev_ready) begin
                status_due_q.push_back(apply_event(
                    i_ev_opcode, i_ev_err_code, i_ev_sub_err, i_ev_is_ext, i_ev_phase,
                    i_ev_progress,
                    (i_ev_file_count | i_ev_folder_count | i_ev_total_amount |
                     i_ev_elapsed_sec) != '0,
                    i_ev_send_ok));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= status_due_q.size();
    end

endmodule

[tb/backup_job_tracker_test.sv]
// Top of the backup job tracker testbench: clock, reset, event stimulus and verdict.
module backup_job_tracker_test;
    import bjt_pkg::*;

    localparam t_opcode OP_SPARE_LO    = 3'd6;
    localparam t_opcode OP_SPARE_HI    = 3'd7;
    localparam int      WATCHDOG_LIMIT = 2000;
    localparam int      PHASE_ITEMS    = 150;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [CODE_W-1:0]    i_cfg_data     = '0;
    logic                 i_valid        = 1'b0;
    logic [OPC_W-1:0]     i_opcode       = '0;
    logic [CODE_W-1:0]    i_err_code     = '0;
    logic [CODE_W-1:0]    i_sub_err      = '0;
    logic                 i_is_ext       = 1'b0;
    logic [CODE_W-1:0]    i_phase        = '0;
    logic [CODE_W-1:0]    i_progress     = '0;
    logic [STAT_W-1:0]    i_file_count   = '0;
    logic [STAT_W-1:0]    i_folder_count = '0;
    logic [STAT_W-1:0]    i_total_amount = '0;
    logic [STAT_W-1:0]    i_elapsed_sec  = '0;
    logic                 i_send_ok      = 1'b0;
    logic                 i_ready        = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [STATE_W-1:0]   o_job_state;
    logic [CODE_W-1:0]    o_last_err;
    logic [CODE_W-1:0]    o_last_sub_err;
    logic                 o_has_ext;
    logic [CODE_W-1:0]    o_cur_phase;
    logic [CODE_W-1:0]    o_cur_progress;
    logic                 o_accepted;
    logic [CNT_W-1:0]     o_change_count;

    int    fail_count;
    int    pending;
    int    items_sent  = 0;
    int    send_idle   = 16;
    int    recv_idle   = 70;
    int    idle_cycles = 0;
    t_code failed_cfg  = FAILED_CODE_RST;
    t_code cancel_cfg  = CANCELLED_CODE_RST;

    backup_job_tracker uut (.*);

    job_status_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_ev_valid        (i_valid),
        .i_ev_ready        (o_ready),
        .i_ev_opcode       (i_opcode),
        .i_ev_err_code     (i_err_code),
        .i_ev_sub_err      (i_sub_err),
        .i_ev_is_ext       (i_is_ext),
        .i_ev_phase        (i_phase),
        .i_ev_progress     (i_progress),
        .i_ev_file_count   (i_file_count),
        .i_ev_folder_count (i_folder_count),
        .i_ev_total_amount (i_total_amount),
        .i_ev_elapsed_sec  (i_elapsed_sec),
        .i_ev_send_ok      (i_send_ok),
        .i_st_valid        (o_valid),
        .i_st_ready        (i_ready),
        .i_st_job_state    (o_job_state),
        .i_st_last_err     (o_last_err),
        .i_st_last_sub_err (o_last_sub_err),
        .i_st_has_ext      (o_has_ext),
        .i_st_cur_phase    (o_cur_phase),
        .i_st_cur_progress (o_cur_progress),
        .i_st_accepted     (o_accepted),
        .i_st_change_count (o_change_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[backup_job_tracker] ERROR");
            $finish;
        end
    end

    function automatic t_code rbyte();
        return t_code'($urandom_range(0, 255));
    endfunction

    function automatic logic rbit();
        return logic'($urandom_range(0, 1));
    endfunction

    function automatic t_code pick_err();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return '0;
            5:             return failed_cfg;
            6:             return cancel_cfg;
            default:       return rbyte();
        endcase
    endfunction

    // four 32-bit statistics, each nonzero with the given percentage
    function automatic logic [127:0] pick_stats(input int pct);
        logic [127:0] s;
        s = '0;
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 99) < pct) begin
                s[32*k +: 32] = $urandom();
            end
        end
        return s;
    endfunction

    task automatic post_event(
        input t_opcode      op,
        input t_code        err,
        input t_code        sub,
        input logic         ext,
        input t_code        ph,
        input t_code        prog,
        input logic [127:0] stats,
        input logic         ok
    );
        int gap;
        gap = 0;
        if (items_sent < 260) begin
            send_idle = 16;
            recv_idle = 70;
        end else if (items_sent < 520) begin
            send_idle = 70;
            recv_idle = 16;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        while ($urandom_range(0, 99) < send_idle) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_err_code     <= err;
        i_sub_err      <= sub;
        i_is_ext       <= ext;
        i_phase        <= ph;
        i_progress     <= prog;
        i_file_count   <= stats[31:0];
        i_folder_count <= stats[63:32];
        i_total_amount <= stats[95:64];
        i_elapsed_sec  <= stats[127:96];
        i_send_ok      <= ok;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_codes(input t_code fcode, input t_code ccode);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FAILED_CODE;
        i_cfg_data <= fcode;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CANCELLED_CODE;
        i_cfg_data <= ccode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        failed_cfg = fcode;
        cancel_cfg = ccode;
    endtask

    // mostly complete jobs with random content, the rest random events
    task automatic run_random(input int count);
        int   stop_at;
        int   n_rep;
        logic ext;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                post_event(t_opcode'($urandom_range(0, 7)), rbyte(), rbyte(), rbit(),
                           rbyte(), rbyte(), pick_stats(50), rbit());
            end else begin
                post_event(OP_START_REQ, rbyte(), rbyte(), rbit(), rbyte(), rbyte(),
                           pick_stats(30), $urandom_range(0, 9) != 0);
                post_event(OP_START_ACK, ($urandom_range(0, 7) == 0) ? rbyte() : t_code'(0),
                           rbyte(), rbit(), rbyte(), rbyte(), pick_stats(30), rbit());
                n_rep = $urandom_range(0, 4);
                repeat (n_rep) begin
                    ext = ($urandom_range(0, 3) != 0);
                    post_event(OP_REPORT, ($urandom_range(0, 4) == 0) ? rbyte() : t_code'(0),
                               rbyte(), ext, t_code'($urandom_range(1, 255)), rbyte(),
                               ext ? pick_stats(50) : '0, rbit());
                end
                if ($urandom_range(0, 3) == 0) begin
                    post_event(OP_CANCEL_REQ, rbyte(), rbyte(), rbit(), rbyte(), rbyte(),
                               pick_stats(30), rbit());
                    post_event(OP_CANCEL_ACK, ($urandom_range(0, 3) == 0) ? rbyte() : t_code'(0),
                               rbyte(), rbit(), rbyte(), rbyte(), pick_stats(30), rbit());
                end
                case ($urandom_range(0, 4))
                    0: post_event(OP_REPORT, pick_err(), rbyte(), 1'b1, '0, rbyte(),
                                  pick_stats(50), rbit());
                    1: post_event(OP_REPORT, pick_err(), rbyte(), 1'b0, rbyte(), rbyte(),
                                  pick_stats(100), rbit());
                    2: post_event(OP_REPORT, failed_cfg, rbyte(), rbit(), rbyte(), rbyte(),
                                  pick_stats(30), rbit());
                    3: post_event(OP_REPORT, cancel_cfg, rbyte(), rbit(), rbyte(), rbyte(),
                                  pick_stats(30), rbit());
                    default: post_event(OP_POWER_DROP, rbyte(), rbyte(), rbit(), rbyte(),
                                        rbyte(), pick_stats(30), rbit());
                endcase
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the job states with the reset codes
        post_event(OP_REPORT, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_START_REQ, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_START_REQ, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b1);
        post_event(OP_START_REQ, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b1);
        post_event(OP_START_ACK, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_START_ACK, 8'h55, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_CANCEL_REQ, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b1);
        post_event(OP_CANCEL_REQ, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_CANCEL_ACK, 8'h2a, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_CANCEL_ACK, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_REPORT, CANCELLED_CODE_RST, 8'd3, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_CANCEL_REQ, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b1);
        post_event(OP_START_REQ, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, '1, 1'b1);
        post_event(OP_START_ACK, 8'hff, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_START_REQ, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b1);
        post_event(OP_REPORT, 8'd0, 8'hff, 1'b1, 8'hff, 8'hff, '0, 1'b1);
        post_event(OP_REPORT, 8'd0, 8'd0, 1'b1, 8'd0, 8'd100, '1, 1'b0);
        post_event(OP_START_REQ, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b1);
        post_event(OP_START_ACK, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_REPORT, 8'd0, 8'd1, 1'b0, 8'h7f, 8'h7f, '1, 1'b0);
        post_event(OP_POWER_DROP, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, '1, 1'b1);
        post_event(OP_REPORT, 8'd0, 8'd0, 1'b1, 8'd1, 8'd0, '0, 1'b0);
        post_event(OP_REPORT, FAILED_CODE_RST, 8'h80, 1'b0, 8'd0, 8'd0, '0, 1'b0);
        post_event(OP_SPARE_LO, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, '1, 1'b1);
        post_event(OP_SPARE_HI, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, '0, 1'b0);

        run_random(PHASE_ITEMS);
        write_codes(8'd0, 8'd255);
        run_random(PHASE_ITEMS);
        write_codes(8'd255, 8'd0);
        run_random(PHASE_ITEMS);
        // equal codes: cancelled takes precedence
        write_codes(8'd7, 8'd7);
        run_random(PHASE_ITEMS);
        write_codes(rbyte(), rbyte());
        run_random(PHASE_ITEMS);

        drain();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[backup_job_tracker] OK");
        end else begin
            $display("[backup_job_tracker] ERROR");
        end
        $finish;
    end

endmodule
